[src/quaternion_vector_rotate_unit_assert.svh]
// Assertion macros for the rotation unit.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define QVR_ASSERT_IMPL(lbl, lhs, rhs, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);

// Check a condition on every clock edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

[src/qvr_pkg.sv]
package qvr_pkg;

    localparam int VEC_WIDTH  = 32;
    localparam int QUAT_WIDTH = 16;
    localparam int THR_WIDTH  = 16;
    localparam int SQ_WIDTH   = 2 * QUAT_WIDTH;
    localparam int M_WIDTH    = SQ_WIDTH + 2;
    localparam int N_WIDTH    = SQ_WIDTH + 1;
    localparam int LO_WIDTH   = 16;
    localparam int HI_WIDTH   = VEC_WIDTH - LO_WIDTH;
    localparam int PLO_WIDTH  = M_WIDTH + LO_WIDTH + 1;
    localparam int PHI_WIDTH  = M_WIDTH + HI_WIDTH;
    localparam int PROD_WIDTH = M_WIDTH + VEC_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int Q_BITS     = SUM_WIDTH - N_WIDTH - 1;
    localparam int LANES      = 3;

    typedef struct packed {
        logic                                   valid;
        logic                                   zero;
        logic [N_WIDTH-1:0]                     n;
        logic [8:0][M_WIDTH-1:0]                m;
        logic [LANES-1:0][VEC_WIDTH-1:0]        v;
    } mat_t;

    typedef struct packed {
        logic                                   valid;
        logic                                   zero;
        logic [N_WIDTH-1:0]                     n;
        logic [LANES-1:0]                       neg;
        logic [LANES-1:0][SUM_WIDTH-1:0]        mag;
    } mag_t;

    typedef struct packed {
        logic                                   valid;
        logic                                   zero;
        logic [N_WIDTH-1:0]                     n;
        logic [LANES-1:0]                       neg;
        logic [LANES-1:0]                       ovf;
        logic [LANES-1:0][Q_BITS-1:0]           q;
        logic [LANES-1:0][N_WIDTH-1:0]          r;
    } quo_t;

endpackage

[src/qvr_matrix.sv]
module qvr_matrix (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    valid,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]          quat_w,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]          quat_x,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]          quat_y,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]          quat_z,
    input  logic [qvr_pkg::LANES-1:0][qvr_pkg::VEC_WIDTH-1:0] vec,
    output qvr_pkg::mat_t                           mat
);

    localparam int SW = qvr_pkg::SQ_WIDTH;
    localparam int MW = qvr_pkg::M_WIDTH;
    localparam int NW = qvr_pkg::N_WIDTH;

    logic [3:0][SW-1:0] sq_reg, sq_next;
    logic [5:0][SW-1:0] cr_reg, cr_next;
    logic [qvr_pkg::LANES-1:0][qvr_pkg::VEC_WIDTH-1:0] v_reg;
    logic valid_reg;
    qvr_pkg::mat_t mat_reg, mat_next;

    logic signed [MW-1:0] ww, xx, yy, zz;
    logic signed [MW-1:0] xy, wz, xz, wy, yz, wx;
    logic [NW-1:0] n_sum;

    always_comb
    begin
        sq_next[0] = SW'($signed(quat_w) * $signed(quat_w));
        sq_next[1] = SW'($signed(quat_x) * $signed(quat_x));
        sq_next[2] = SW'($signed(quat_y) * $signed(quat_y));
        sq_next[3] = SW'($signed(quat_z) * $signed(quat_z));
        cr_next[0] = SW'($signed(quat_x) * $signed(quat_y));
        cr_next[1] = SW'($signed(quat_w) * $signed(quat_z));
        cr_next[2] = SW'($signed(quat_x) * $signed(quat_z));
        cr_next[3] = SW'($signed(quat_w) * $signed(quat_y));
        cr_next[4] = SW'($signed(quat_y) * $signed(quat_z));
        cr_next[5] = SW'($signed(quat_w) * $signed(quat_x));
    end

    always_comb
    begin
        ww = MW'($signed(sq_reg[0]));
        xx = MW'($signed(sq_reg[1]));
        yy = MW'($signed(sq_reg[2]));
        zz = MW'($signed(sq_reg[3]));
        xy = MW'($signed(cr_reg[0]));
        wz = MW'($signed(cr_reg[1]));
        xz = MW'($signed(cr_reg[2]));
        wy = MW'($signed(cr_reg[3]));
        yz = MW'($signed(cr_reg[4]));
        wx = MW'($signed(cr_reg[5]));
        n_sum = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
        mat_next.valid = valid_reg;
        mat_next.zero  = (n_sum == '0);
        mat_next.n     = n_sum;
        mat_next.v     = v_reg;
        mat_next.m[0]  = ww + xx - yy - zz;
        mat_next.m[1]  = (xy - wz) <<< 1;
        mat_next.m[2]  = (xz + wy) <<< 1;
        mat_next.m[3]  = (xy + wz) <<< 1;
        mat_next.m[4]  = ww - xx + yy - zz;
        mat_next.m[5]  = (yz - wx) <<< 1;
        mat_next.m[6]  = (xz - wy) <<< 1;
        mat_next.m[7]  = (yz + wx) <<< 1;
        mat_next.m[8]  = ww - xx - yy + zz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            mat_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
            mat_reg   <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
            cr_reg <= cr_next;
            v_reg  <= vec;
        end
    end

    assign mat = mat_reg;

endmodule

[src/qvr_mac.sv]
module qvr_mac (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  qvr_pkg::mat_t mat,
    output qvr_pkg::mag_t mag
);

    localparam int MW = qvr_pkg::M_WIDTH;
    localparam int LW = qvr_pkg::LO_WIDTH;
    localparam int HW = qvr_pkg::HI_WIDTH;
    localparam int PW = qvr_pkg::PROD_WIDTH;
    localparam int SW = qvr_pkg::SUM_WIDTH;
    localparam int VW = qvr_pkg::VEC_WIDTH;
    localparam int L  = qvr_pkg::LANES;

    logic [8:0][qvr_pkg::PLO_WIDTH-1:0] plo_reg, plo_next;
    logic [8:0][qvr_pkg::PHI_WIDTH-1:0] phi_reg, phi_next;
    logic [8:0][PW-1:0]                 term_reg, term_next;
    logic [L-1:0][SW-1:0]               sum_reg, sum_next;
    logic [2:0]                         valid_reg;
    logic [2:0]                         zero_reg;
    logic [2:0][qvr_pkg::N_WIDTH-1:0]   n_reg;
    qvr_pkg::mag_t                      mag_reg, mag_next;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            plo_next[i] = $signed(mat.m[i]) * $signed({1'b0, mat.v[i % L][LW-1:0]});
            phi_next[i] = $signed(mat.m[i]) * $signed(mat.v[i % L][VW-1:LW]);
            term_next[i] = (PW'($signed(phi_reg[i])) <<< LW) + PW'($signed(plo_reg[i]));
        end
        for (int k = 0; k < L; k++)
        begin
            sum_next[k] = SW'($signed(term_reg[3*k])) + SW'($signed(term_reg[3*k+1]))
                        + SW'($signed(term_reg[3*k+2]));
            mag_next.neg[k] = sum_reg[k][SW-1];
            mag_next.mag[k] = sum_reg[k][SW-1] ? SW'(-sum_reg[k]) : sum_reg[k];
        end
        mag_next.valid = valid_reg[2];
        mag_next.zero  = zero_reg[2];
        mag_next.n     = n_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            mag_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], mat.valid};
            mag_reg   <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            term_reg <= term_next;
            sum_reg  <= sum_next;
            zero_reg <= {zero_reg[1:0], mat.zero};
            n_reg    <= {n_reg[1:0], mat.n};
        end
    end

    assign mag = mag_reg;

endmodule

[src/qvr_div_step.sv]
module qvr_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  qvr_pkg::quo_t quo_in,
    input  logic [qvr_pkg::LANES-1:0][qvr_pkg::Q_BITS-1:0] low_in,
    output qvr_pkg::quo_t quo_out,
    output logic [qvr_pkg::LANES-1:0][qvr_pkg::Q_BITS-1:0] low_out
);

    localparam int NW = qvr_pkg::N_WIDTH;
    localparam int QB = qvr_pkg::Q_BITS;

    qvr_pkg::quo_t quo_reg, quo_next;
    logic [qvr_pkg::LANES-1:0][QB-1:0] low_reg, low_next;
    logic [NW:0] t;
    logic ge;

    always_comb
    begin
        quo_next = quo_in;
        t = '0;
        ge = 1'b0;
        for (int k = 0; k < qvr_pkg::LANES; k++)
        begin
            t = {quo_in.r[k], low_in[k][QB-1]};
            ge = (t >= {1'b0, quo_in.n});
            quo_next.r[k] = ge ? NW'(t - {1'b0, quo_in.n}) : t[NW-1:0];
            quo_next.q[k] = {quo_in.q[k][QB-2:0], ge};
            low_next[k] = {low_in[k][QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quo_reg.valid <= 1'b0;
        else if (en)
            quo_reg <= quo_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            low_reg <= low_next;
    end

    assign quo_out = quo_reg;
    assign low_out = low_reg;

endmodule

[src/quaternion_vector_rotate_unit.sv]
// Channel   Valid       Stall       Payload
// request   quat_valid  quat_stall  quat_w/x/y/z, vec_x/y/z
// result    rot_valid   rot_stall   rot_x/y/z, zero_quaternion
// config    cfg_wr_en   -           cfg_wr_data (near-zero threshold)
// One request enters per cycle unless quat_stall is high; a one-bit-per-stage restoring divider
// sits behind the matrix and multiply stages.
// Reset clears every valid bit and loads the threshold with 1.
// A stalled result freezes the whole pipeline; quat_stall is rot_valid and rot_stall.
module quaternion_vector_rotate_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [qvr_pkg::THR_WIDTH-1:0]      cfg_wr_data,
    input  logic                               quat_valid,
    output logic                               quat_stall,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]     quat_w,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]     quat_x,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]     quat_y,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]     quat_z,
    input  logic [qvr_pkg::VEC_WIDTH-1:0]      vec_x,
    input  logic [qvr_pkg::VEC_WIDTH-1:0]      vec_y,
    input  logic [qvr_pkg::VEC_WIDTH-1:0]      vec_z,
    output logic                               rot_valid,
    input  logic                               rot_stall,
    output logic [qvr_pkg::VEC_WIDTH-1:0]      rot_x,
    output logic [qvr_pkg::VEC_WIDTH-1:0]      rot_y,
    output logic [qvr_pkg::VEC_WIDTH-1:0]      rot_z,
    output logic                               zero_quaternion
);

    localparam int VW = qvr_pkg::VEC_WIDTH;
    localparam int NW = qvr_pkg::N_WIDTH;
    localparam int QB = qvr_pkg::Q_BITS;
    localparam int SW = qvr_pkg::SUM_WIDTH;
    localparam int L  = qvr_pkg::LANES;

    logic                          en;
    logic [qvr_pkg::THR_WIDTH-1:0] thr_reg;
    qvr_pkg::mat_t                 mat;
    qvr_pkg::mag_t                 mag;
    qvr_pkg::quo_t                 quo [QB+1];
    logic [L-1:0][QB-1:0]          low [QB+1];
    qvr_pkg::quo_t                 init_reg, init_next;
    logic [L-1:0][QB-1:0]          init_low_reg;
    logic [L-1:0][VW-1:0]          res_reg, res_next;
    logic                          valid_reg;
    logic                          zero_reg;
    logic [QB:0]                   qr;
    logic [QB:0]                   lim;
    logic [VW-1:0]                 qm;

    assign en = !(valid_reg && rot_stall);
    assign quat_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qvr_pkg::THR_WIDTH'(1);
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    qvr_matrix u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .valid  (quat_valid),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .vec    ({vec_z, vec_y, vec_x}),
        .mat    (mat)
    );

    qvr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .mat   (mat),
        .mag   (mag)
    );

    // load the top half as the first partial remainder; flag overflow past the quotient width
    always_comb
    begin
        init_next.valid = mag.valid;
        init_next.zero  = mag.zero;
        init_next.n     = mag.n;
        init_next.neg   = mag.neg;
        init_next.q     = '0;
        for (int k = 0; k < L; k++)
        begin
            init_next.ovf[k] = (mag.mag[k][SW-1:QB] >= {1'b0, mag.n});
            init_next.r[k]   = mag.mag[k][SW-2:QB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_reg.valid <= 1'b0;
        else if (en)
            init_reg <= init_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < L; k++)
                init_low_reg[k] <= mag.mag[k][QB-1:0];
        end
    end

    assign quo[0] = init_reg;
    assign low[0] = init_low_reg;

    for (genvar s = 0; s < QB; s++)
    begin : g_div
        qvr_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .quo_in  (quo[s]),
            .low_in  (low[s]),
            .quo_out (quo[s+1]),
            .low_out (low[s+1])
        );
    end

    // round half away, saturate, then clear near-zero components and all components of a zero quaternion
    always_comb
    begin
        qr = '0;
        lim = '0;
        qm = '0;
        for (int k = 0; k < L; k++)
        begin
            qr = {1'b0, quo[QB].q[k][QB-1:0]}
               + (QB+1)'({quo[QB].r[k], 1'b0} >= {1'b0, quo[QB].n});
            lim = quo[QB].neg[k] ? ((QB+1)'(1) << (VW-1)) : (((QB+1)'(1) << (VW-1)) - 1'b1);
            qm = (quo[QB].ovf[k] || qr > lim) ? lim[VW-1:0] : qr[VW-1:0];
            if (quo[QB].zero || qm <= VW'(thr_reg))
                res_next[k] = '0;
            else
                res_next[k] = quo[QB].neg[k] ? VW'(-qm) : qm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= quo[QB].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= res_next;
            zero_reg <= quo[QB].zero;
        end
    end

    assign rot_valid       = valid_reg;
    assign rot_x           = res_reg[0];
    assign rot_y           = res_reg[1];
    assign rot_z           = res_reg[2];
    assign zero_quaternion = zero_reg;

    `include "quaternion_vector_rotate_unit_assert.svh"

    `QVR_ASSERT_ALWAYS(a_stall_backpressure, quat_stall == (rot_valid && rot_stall), "stall mismatch")
    `QVR_ASSERT_IMPL(a_zero_quat_clears, rot_valid && zero_quaternion, rot_x == '0 && rot_y == '0 && rot_z == '0, "zero quaternion result not cleared")
    `QVR_ASSERT_IMPL(a_near_zero_x, rot_valid && !rot_x[VW-1] && rot_x != '0, rot_x > VW'(thr_reg), "positive x at or below threshold")

endmodule
